FILE: rtl/rcfp_pkg.sv
`timescale 1ns / 1ps

package rcfp_pkg;

    localparam logic [7:0] HDR_DOLLAR = 8'h24;
    localparam logic [7:0] HDR_R      = 8'h52;
    localparam logic [7:0] HDR_C      = 8'h43;

    typedef enum logic [2:0] {
        POS_DOLLAR  = 3'd0,
        POS_R       = 3'd1,
        POS_C       = 3'd2,
        POS_CHANNEL = 3'd3,
        POS_VAL_LO  = 3'd4,
        POS_VAL_HI  = 3'd5,
        POS_CHECK   = 3'd6
    } t_pos;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  channel;
    } t_result;

endpackage

FILE: rtl/rcfp_parser.sv
`timescale 1ns / 1ps

module rcfp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    output logic             o_valid,
    output rcfp_pkg::t_result o_result
);
    import rcfp_pkg::*;

    t_pos        r_pos, n_pos;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_channel, n_channel;
    logic [15:0] r_value, n_value;
    logic        n_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_DOLLAR;
            r_xor     <= 8'd0;
            r_channel <= 8'd0;
            r_value   <= 16'd0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_xor     <= n_xor;
            r_channel <= n_channel;
            r_value   <= n_value;
        end
    end

    always_comb begin
        n_pos     = POS_DOLLAR;
        n_xor     = 8'd0;
        n_channel = r_channel;
        n_value   = r_value;
        n_emit    = 1'b0;
        case (r_pos)
            POS_DOLLAR: begin
                if (i_data_byte == HDR_DOLLAR) begin
                    n_pos   = POS_R;
                    n_xor   = r_xor ^ i_data_byte;
                    n_value = 16'd0;
                end
            end
            POS_R: begin
                if (i_data_byte == HDR_R) begin
                    n_pos = POS_C;
                    n_xor = r_xor ^ i_data_byte;
                end
            end
            POS_C: begin
                if (i_data_byte == HDR_C) begin
                    n_pos = POS_CHANNEL;
                    n_xor = r_xor ^ i_data_byte;
                end
            end
            POS_CHANNEL: begin
                n_pos     = POS_VAL_LO;
                n_xor     = r_xor ^ i_data_byte;
                n_channel = i_data_byte;
            end
            POS_VAL_LO: begin
                n_pos   = POS_VAL_HI;
                n_xor   = r_xor ^ i_data_byte;
                n_value = {8'd0, i_data_byte};
            end
            POS_VAL_HI: begin
                n_pos   = POS_CHECK;
                n_xor   = r_xor ^ i_data_byte;
                n_value = {i_data_byte, r_value[7:0]};
            end
            POS_CHECK: begin
                // checksum word: restart either way, emit only on match
                n_emit = (r_xor == i_data_byte);
            end
            default: begin
                n_pos = POS_DOLLAR;
            end
        endcase
    end

    assign o_valid          = i_accept && n_emit;
    assign o_result.channel = r_channel;
    assign o_result.value   = r_value;

endmodule

FILE: rtl/rcfp_out_skid.sv
`timescale 1ns / 1ps

module rcfp_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rcfp_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_valid,
    output rcfp_pkg::t_result o_result,
    input  logic              i_ready
);
    import rcfp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            // output slot free: drain the skid word first, else take the new one
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_valid) begin
            r_skid <= i_result;
        end
    end

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: rtl/rc_channel_frame_parser.sv
`timescale 1ns / 1ps
// A frame's result is registered into the output register (skid stage on a stall).
// Throughput: one byte per cycle while ready; parser state updates per accepted word.
// s_axis_tready drops only while both the output register and skid stage hold words.
// Reset (i_rst_n low, synchronous) returns the parser to waiting for '$',
// clears the running checksum and empties the output stage.

module rc_channel_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] channel, [23:8] value
);
    import rcfp_pkg::*;

    logic    s_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    rcfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_data_byte (s_axis_tdata),
        .o_valid     (res_valid),
        .o_result    (res)
    );

    rcfp_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_result (res),
        .o_ready  (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (out_res),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {out_res.value, out_res.channel};

endmodule

FILE: rtl/rcfp_checker.sv
`timescale 1ns / 1ps

module rcfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a new result needs a word accepted the cycle before
    a_rise_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared without an accepted word");

    // input only stalls while results are backed up
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind rc_channel_frame_parser rcfp_checker u_rcfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
